### hdl/bcd_calendar_clock_core_defines.svh
// ----------------------------------------------------------------------------
// BCD calendar clock assertion macros
// Shared concurrent assertion forms for the calendar clock RTL.
// ----------------------------------------------------------------------------
`ifndef BCD_CALENDAR_CLOCK_CORE_DEFINES_SVH
`define BCD_CALENDAR_CLOCK_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// BCD calendar clock package
// Request and result types, clock state type, limits and BCD helpers.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // Action codes carried by a request.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Calendar limits.
    localparam logic [6:0] YEAR_LAST    = 7'd99;
    localparam logic [3:0] MONTH_FIRST  = 4'd1;
    localparam logic [3:0] MONTH_LAST   = 4'd12;
    localparam logic [3:0] FEBRUARY     = 4'd2;
    localparam logic [4:0] DAY_FIRST    = 5'd1;
    localparam logic [4:0] DAY_LAST     = 5'd31;
    localparam logic [5:0] LEAP_DAY     = 6'd29;
    localparam logic [2:0] WEEKDAY_LAST = 3'd6;
    localparam logic [4:0] HOUR_LAST_24 = 5'd23;
    localparam logic [4:0] HOUR_LAST_12 = 5'd11;
    localparam logic [4:0] HOUR_NOON    = 5'd12;
    localparam logic [4:0] HOUR_DAY     = 5'd24;
    localparam logic [5:0] MINUTE_LAST  = 6'd59;
    localparam logic [5:0] SECOND_LAST  = 6'd59;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] set_year_byte;
        logic [7:0] set_month_byte;
        logic [7:0] set_day_byte;
        logic [7:0] set_weekday_hour_byte;
        logic [7:0] set_hour_minute_byte;
        logic [7:0] set_minute_second_byte;
        logic [7:0] set_second_byte;
    } t_bcc_in;

    typedef struct packed {
        logic [7:0] year_out;
        logic [7:0] month_out;
        logic [7:0] day_out;
        logic [7:0] weekday_hour_out;
        logic [7:0] hour_minute_out;
        logic [7:0] minute_second_out;
        logic [7:0] second_out;
    } t_bcc_out;

    // Clock state, all fields in binary.
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       afternoon;
        logic       mode_24h;
    } t_bcc_time;

    localparam t_bcc_time TIME_RESET = '{
        year: 7'd0, month: 4'd1, day: 5'd1, weekday: 3'd0, hour: 5'd0,
        minute: 6'd0, second: 6'd0, afternoon: 1'b0, mode_24h: 1'b0
    };

    // Number of days in a month, February without the leap day.
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Combine two nibbles as tens * 10 + units; nibbles above 9 count in binary.
    function automatic logic [7:0] two_digits(input logic [3:0] t, input logic [3:0] u);
        return {1'b0, t, 3'b000} + {3'b000, t, 1'b0} + {4'b0000, u};
    endfunction

    // Weekday nibble reduced modulo 7.
    function automatic logic [2:0] mod7(input logic [3:0] v);
        logic [3:0] r;
        if (v >= 4'd14) begin
            r = v - 4'd14;
        end else if (v >= 4'd7) begin
            r = v - 4'd7;
        end else begin
            r = v;
        end
        return r[2:0];
    endfunction

    // Binary to two BCD digits; the tens digit comes from a reciprocal multiply.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [17:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        prod     = 18'(v) * 18'd205;
        tens     = prod[14:11];
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        units    = v - tens_x10;
        return {tens, units[3:0]};
    endfunction

    // Pack the clock state into the seven result bytes.
    function automatic t_bcc_out format_time(input t_bcc_time t);
        t_bcc_out   r;
        logic [7:0] hour_bcd;
        logic [7:0] min_bcd;
        logic [7:0] sec_bcd;
        logic [7:0] day_bcd;
        hour_bcd = to_bcd({2'b00, t.hour});
        min_bcd  = to_bcd({1'b0, t.minute});
        sec_bcd  = to_bcd({1'b0, t.second});
        day_bcd  = to_bcd({2'b00, t.day});
        r.year_out          = to_bcd(t.year);
        r.month_out         = to_bcd({3'b000, t.month});
        r.day_out           = {2'b00, day_bcd[5:0]};
        r.weekday_hour_out  = {1'b0, t.weekday, t.mode_24h,
                               (!t.mode_24h && t.afternoon), hour_bcd[5:4]};
        r.hour_minute_out   = {hour_bcd[3:0], min_bcd[7:4]};
        r.minute_second_out = {min_bcd[3:0], sec_bcd[7:4]};
        r.second_out        = {sec_bcd[3:0], 4'b0000};
        return r;
    endfunction

endpackage

### hdl/bcc_time_update.sv
// ----------------------------------------------------------------------------
// BCD calendar clock state update
// Holds the clock state and works out its value after one request.
// ----------------------------------------------------------------------------
`include "bcd_calendar_clock_core_defines.svh"

module bcc_time_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  bcc_pkg::t_bcc_in   i_item,
    output bcc_pkg::t_bcc_time o_time_next
);
    import bcc_pkg::*;

    t_bcc_time  r_time;
    t_bcc_time  n_time;
    t_bcc_time  t_tick;
    t_bcc_time  t_set;
    t_bcc_time  t_sel;

    logic [4:0] hour_inc;
    logic       roll_day;
    logic [3:0] month_cl;
    logic [5:0] day_inc;
    logic       leap_ok;
    logic       past_end;
    logic [7:0] set_year;
    logic [7:0] set_month;
    logic [7:0] set_day;
    logic [7:0] set_hour;
    logic [7:0] set_minute;
    logic [7:0] set_second;

    // Day rollover: next day, month and year.
    assign hour_inc = r_time.hour + 5'd1;
    assign month_cl = (r_time.month < MONTH_FIRST) ? MONTH_FIRST :
                      (r_time.month > MONTH_LAST)  ? MONTH_LAST  : r_time.month;
    assign day_inc  = {1'b0, r_time.day} + 6'd1;
    assign leap_ok  = (month_cl == FEBRUARY) && (day_inc == LEAP_DAY) &&
                      (r_time.year[1:0] == 2'b00);
    assign past_end = (day_inc > {1'b0, month_days(month_cl)}) && !leap_ok;

    // One-second tick.
    always_comb begin
        t_tick   = r_time;
        roll_day = 1'b0;
        if (r_time.second < SECOND_LAST) begin
            t_tick.second = r_time.second + 6'd1;
        end else begin
            t_tick.second = 6'd0;
            if (r_time.minute < MINUTE_LAST) begin
                t_tick.minute = r_time.minute + 6'd1;
            end else begin
                t_tick.minute = 6'd0;
                if (r_time.mode_24h) begin
                    t_tick.afternoon = (hour_inc >= HOUR_NOON);
                    if (hour_inc < HOUR_DAY) begin
                        t_tick.hour = hour_inc;
                    end else begin
                        roll_day = 1'b1;
                    end
                end else if (hour_inc < HOUR_NOON) begin
                    t_tick.hour = hour_inc;
                end else if (!r_time.afternoon) begin
                    t_tick.afternoon = 1'b1;
                    t_tick.hour      = 5'd0;
                end else begin
                    roll_day = 1'b1;
                end
            end
        end
        if (roll_day) begin
            t_tick.hour      = 5'd0;
            t_tick.afternoon = 1'b0;
            t_tick.weekday   = (r_time.weekday >= WEEKDAY_LAST) ? 3'd0
                                                                : r_time.weekday + 3'd1;
            if (past_end) begin
                t_tick.day = DAY_FIRST;
                if (month_cl == MONTH_LAST) begin
                    t_tick.month = MONTH_FIRST;
                    t_tick.year  = (r_time.year >= YEAR_LAST) ? 7'd0 : r_time.year + 7'd1;
                end else begin
                    t_tick.month = month_cl + 4'd1;
                end
            end else begin
                t_tick.day   = day_inc[4:0];
                t_tick.month = month_cl;
            end
        end
    end

    // Decode of the set bytes.
    assign set_year   = two_digits(i_item.set_year_byte[7:4], i_item.set_year_byte[3:0]);
    assign set_month  = two_digits(i_item.set_month_byte[7:4], i_item.set_month_byte[3:0]);
    assign set_day    = two_digits({2'b00, i_item.set_day_byte[5:4]},
                                   i_item.set_day_byte[3:0]);
    assign set_hour   = two_digits({2'b00, i_item.set_weekday_hour_byte[1:0]},
                                   i_item.set_hour_minute_byte[7:4]);
    assign set_minute = two_digits(i_item.set_hour_minute_byte[3:0],
                                   i_item.set_minute_second_byte[7:4]);
    assign set_second = two_digits(i_item.set_minute_second_byte[3:0],
                                   i_item.set_second_byte[7:4]);

    // Set from bytes, each value held to its legal range.
    always_comb begin
        t_set.year     = (set_year > {1'b0, YEAR_LAST}) ? YEAR_LAST : set_year[6:0];
        if (set_month < {4'd0, MONTH_FIRST}) begin
            t_set.month = MONTH_FIRST;
        end else if (set_month > {4'd0, MONTH_LAST}) begin
            t_set.month = MONTH_LAST;
        end else begin
            t_set.month = set_month[3:0];
        end
        if (set_day < {3'd0, DAY_FIRST}) begin
            t_set.day = DAY_FIRST;
        end else if (set_day > {3'd0, DAY_LAST}) begin
            t_set.day = DAY_LAST;
        end else begin
            t_set.day = set_day[4:0];
        end
        t_set.weekday  = mod7(i_item.set_weekday_hour_byte[7:4]);
        t_set.mode_24h = i_item.set_weekday_hour_byte[3];
        if (t_set.mode_24h) begin
            t_set.hour      = (set_hour > {3'd0, HOUR_LAST_24}) ? HOUR_LAST_24 : set_hour[4:0];
            t_set.afternoon = (t_set.hour >= HOUR_NOON);
        end else begin
            t_set.hour      = (set_hour > {3'd0, HOUR_LAST_12}) ? HOUR_LAST_12 : set_hour[4:0];
            t_set.afternoon = i_item.set_weekday_hour_byte[2];
        end
        t_set.minute = (set_minute > {2'd0, MINUTE_LAST}) ? MINUTE_LAST : set_minute[5:0];
        t_set.second = (set_second > {2'd0, SECOND_LAST}) ? SECOND_LAST : set_second[5:0];
    end

    // Pick the action; a read or an unknown action leaves the state alone.
    always_comb begin
        case (i_item.action)
            ACT_TICK: t_sel = t_tick;
            ACT_SET:  t_sel = t_set;
            ACT_READ: t_sel = r_time;
            default:  t_sel = r_time;
        endcase
    end

    assign n_time      = i_fire ? t_sel : r_time;
    assign o_time_next = t_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= TIME_RESET;
        end else begin
            r_time <= n_time;
        end
    end

    `BCC_ASSERT_SAME(a_time_range, i_clk, i_rst_n, 1'b1,
        (r_time.second <= SECOND_LAST) && (r_time.minute <= MINUTE_LAST) &&
        (r_time.hour <= HOUR_LAST_24) && (r_time.weekday <= WEEKDAY_LAST),
        "clock state out of range")
    `BCC_ASSERT_SAME(a_hour_12h, i_clk, i_rst_n, !r_time.mode_24h,
        r_time.hour <= HOUR_LAST_12, "hour beyond 11 in 12-hour mode")
    `BCC_ASSERT_NEXT(a_tick_second, i_clk, i_rst_n,
        i_fire && (i_item.action == ACT_TICK) && (r_time.second < SECOND_LAST),
        (r_time.second == $past(r_time.second) + 6'd1) &&
        (r_time.minute == $past(r_time.minute)),
        "tick did not advance the second alone")

endmodule

### hdl/bcc_out_buffer.sv
// ----------------------------------------------------------------------------
// BCD calendar clock result buffer
// Result register with one skid entry so a request can land during a stall.
// ----------------------------------------------------------------------------
`include "bcd_calendar_clock_core_defines.svh"

module bcc_out_buffer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bcc_pkg::t_bcc_out i_data,
    output logic              o_full,
    output logic              o_valid,
    output bcc_pkg::t_bcc_out o_data,
    input  logic              i_stall
);
    import bcc_pkg::*;

    logic     r_out_valid;
    logic     r_skid_valid;
    t_bcc_out r_out;
    t_bcc_out r_skid;
    logic     out_free;

    assign out_free = !r_out_valid || !i_stall;

    // Valid flags: the skid entry drains first to keep order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BCC_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry held without a result in front")
    `BCC_ASSERT_NEXT(a_push_stalled, i_clk, i_rst_n, i_push && r_out_valid && i_stall,
        r_skid_valid, "request pushed during a stall was not kept")
    `BCC_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_valid && !i_stall && !i_push,
        !r_skid_valid && r_out_valid, "skid entry did not drain")

endmodule

### hdl/bcd_calendar_clock_core.sv
// ----------------------------------------------------------------------------
// BCD calendar clock core
// Two-digit-year calendar clock with 12/24-hour mode: tick, set and read.
// ----------------------------------------------------------------------------
//  Channel   Signals                           Direction  Payload
//  request   i_in_valid  / o_in_stall  / i_in   in         t_bcc_in
//  result    o_out_valid / i_out_stall / o_out  out        t_bcc_out
//
//  Each request's result is registered in the result register, or in the skid
//  entry during a stall; one request can be accepted every cycle unless stalled.
//  The clock state register is updated in the same cycle a request is taken.
//  Reset loads 00-01-01, weekday 0, 0:00:00 AM, 12-hour mode; no clearing pass.
//  During a result stall one more request lands in a skid entry; the request
//  side stalls only while that entry is occupied.
// ----------------------------------------------------------------------------
module bcd_calendar_clock_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bcc_pkg::t_bcc_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bcc_pkg::t_bcc_out o_out
);
    import bcc_pkg::*;

    logic      in_fire;
    logic      buf_full;
    t_bcc_time time_next;
    t_bcc_out  result;

    assign o_in_stall = buf_full;
    assign in_fire    = i_in_valid && !buf_full;

    // Clock state and its next value.
    bcc_time_update u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_item      (i_in),
        .o_time_next (time_next)
    );

    // Result bytes from the state after the request.
    assign result = format_time(time_next);

    bcc_out_buffer u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .i_stall (i_out_stall)
    );

endmodule
